// ===== rtl/core/muart_pkg.sv =====
// Shared package for the MIDI UART port interface.
// Holds the function and event codes, the fixed reply bytes and the
// controller-to-datapath command type. Depends on nothing.
`default_nettype none

package muart_pkg;

	// Input function codes.
	localparam logic [2:0] FUNC_BUS_READ  = 3'd0;
	localparam logic [2:0] FUNC_BUS_WRITE = 3'd1;
	localparam logic [2:0] FUNC_MIDI_IN   = 3'd2;
	localparam logic [2:0] FUNC_CLEAR     = 3'd3;
	localparam logic [2:0] FUNC_RESET     = 3'd4;

	// Bus port selection.
	localparam logic PORT_DATA = 1'b0;
	localparam logic PORT_CMD  = 1'b1;

	// Event codes.
	localparam logic [2:0] EV_NONE     = 3'd0;
	localparam logic [2:0] EV_MIDI_OUT = 3'd1;
	localparam logic [2:0] EV_CMD_FWD  = 3'd2;
	localparam logic [2:0] EV_READ_FWD = 3'd3;
	localparam logic [2:0] EV_STOP     = 3'd4;

	// Fixed bytes.
	localparam logic [7:0] BYTE_ACK       = 8'hFE;
	localparam logic [7:0] BYTE_IDLE      = 8'hFF;
	localparam logic [7:0] BYTE_STATUS    = 8'hBF;
	localparam logic [7:0] STATUS_RX_MASK = 8'h7F;
	localparam logic [7:0] CMD_UART_ON    = 8'h3F;
	localparam logic [7:0] CMD_UART_OFF   = 8'hFF;

	typedef struct packed {
		logic capture;
		logic exec;
	} cmd_t;

endpackage

`default_nettype wire

// ===== rtl/core/muart_ctrl.sv =====
// Controller of the MIDI UART port interface: a two-state sequencer.
// Depends on muart_pkg for the command type.
`default_nettype none

module muart_ctrl (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          start,
	output logic               busy,
	output logic               done,
	output muart_pkg::cmd_t    cmd
);

	localparam logic ST_IDLE = 1'b0;
	localparam logic ST_EXEC = 1'b1;

	logic state_q;
	logic state_d;
	logic done_q;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (start) state_d = ST_EXEC;
			end
			ST_EXEC: begin
				state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= (state_q == ST_EXEC);
		end
	end

	assign busy        = (state_q == ST_EXEC);
	assign done        = done_q;
	assign cmd.capture = (state_q == ST_IDLE) && start;
	assign cmd.exec    = (state_q == ST_EXEC);

endmodule

`default_nettype wire

// ===== rtl/core/muart_dp.sv =====
// Datapath of the MIDI UART port interface: item registers, receive FIFO
// memory with its pointers and count, mode and interrupt flags, result registers.
// Depends on muart_pkg for codes and the command type.
`default_nettype none

module muart_dp #(
	parameter int FIFO_DEPTH = 32,
	parameter int PTR_W      = $clog2(FIFO_DEPTH),
	parameter int CNT_W      = $clog2(FIFO_DEPTH + 1)
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire muart_pkg::cmd_t  cmd,
	input  wire logic [2:0]       func,
	input  wire logic             port_offset,
	input  wire logic [7:0]       data_byte,
	output logic [7:0]            read_data,
	output logic                  irq_line,
	output logic                  irq_run,
	output logic [2:0]            event_kind,
	output logic [7:0]            event_byte,
	output logic                  uart_mode,
	output logic [CNT_W-1:0]      fifo_count
);

	localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(FIFO_DEPTH - 1);
	localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(FIFO_DEPTH);

	logic [2:0]       func_q;
	logic             port_q;
	logic [7:0]       byte_q;

	logic [7:0]       fifo_mem_q [FIFO_DEPTH];
	logic [7:0]       rdata_q;
	logic [PTR_W-1:0] rd_ptr_q, wr_ptr_q;
	logic [CNT_W-1:0] cnt_q;
	logic             uart_q, irq_q;

	logic [7:0]       read_data_q, event_byte_q;
	logic [2:0]       event_kind_q;
	logic             irq_run_q;

	logic [PTR_W-1:0] rd_ptr_d, wr_ptr_d, wr_addr;
	logic [CNT_W-1:0] cnt_d;
	logic             uart_d, irq_d, we;
	logic [7:0]       wdata, rd_d, eb_d;
	logic [2:0]       ek_d;
	logic             run_d;

	function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
		ptr_inc = (p == PTR_LAST) ? '0 : p + 1'b1;
	endfunction

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			func_q <= func;
			port_q <= port_offset;
			byte_q <= data_byte;
		end
	end

	// The head entry is read every cycle; the pointers do not move between
	// the accept cycle and the execute cycle.
	always_ff @(posedge clk) begin
		rdata_q <= fifo_mem_q[rd_ptr_q];
		if (cmd.exec && we) fifo_mem_q[wr_addr] <= wdata;
	end

	always_comb begin
		rd_ptr_d = rd_ptr_q;
		wr_ptr_d = wr_ptr_q;
		cnt_d    = cnt_q;
		uart_d   = uart_q;
		irq_d    = irq_q;
		we       = 1'b0;
		wr_addr  = wr_ptr_q;
		wdata    = byte_q;
		rd_d     = muart_pkg::BYTE_IDLE;
		run_d    = 1'b0;
		ek_d     = muart_pkg::EV_NONE;
		eb_d     = 8'h00;
		unique case (func_q)
			muart_pkg::FUNC_BUS_READ: begin
				if (port_q == muart_pkg::PORT_DATA) begin
					if (cnt_q != '0) begin
						rd_d     = rdata_q;
						rd_ptr_d = ptr_inc(rd_ptr_q);
						cnt_d    = cnt_q - 1'b1;
					end else begin
						rd_d = muart_pkg::BYTE_ACK;
					end
					if (!uart_q) begin
						ek_d = muart_pkg::EV_READ_FWD;
						eb_d = rd_d;
					end
					if (cnt_d == '0) irq_d = 1'b0;
					run_d = 1'b1;
				end else begin
					rd_d = (cnt_q != '0) ? (muart_pkg::BYTE_STATUS & muart_pkg::STATUS_RX_MASK)
					                     : muart_pkg::BYTE_STATUS;
				end
			end
			muart_pkg::FUNC_BUS_WRITE: begin
				if (port_q == muart_pkg::PORT_DATA) begin
					ek_d = muart_pkg::EV_MIDI_OUT;
					eb_d = byte_q;
				end else begin
					// The FIFO is emptied, so the acknowledge byte always fits.
					we       = 1'b1;
					wr_addr  = '0;
					wdata    = muart_pkg::BYTE_ACK;
					rd_ptr_d = '0;
					wr_ptr_d = ptr_inc('0);
					cnt_d    = CNT_W'(1);
					irq_d    = 1'b1;
					if (byte_q == muart_pkg::CMD_UART_ON) begin
						uart_d = 1'b1;
					end else if (byte_q == muart_pkg::CMD_UART_OFF) begin
						uart_d = 1'b0;
						ek_d   = muart_pkg::EV_STOP;
					end else begin
						ek_d = muart_pkg::EV_CMD_FWD;
						eb_d = byte_q;
					end
				end
			end
			muart_pkg::FUNC_MIDI_IN: begin
				if (cnt_q < CNT_FULL) begin
					we       = 1'b1;
					wr_ptr_d = ptr_inc(wr_ptr_q);
					cnt_d    = cnt_q + 1'b1;
					if (cnt_q == '0) irq_d = 1'b1;
				end
			end
			muart_pkg::FUNC_CLEAR: begin
				rd_ptr_d = '0;
				wr_ptr_d = '0;
				cnt_d    = '0;
			end
			muart_pkg::FUNC_RESET: begin
				irq_d  = 1'b0;
				uart_d = 1'b0;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_ptr_q <= '0;
			wr_ptr_q <= '0;
			cnt_q    <= '0;
			uart_q   <= 1'b0;
			irq_q    <= 1'b0;
		end else if (cmd.exec) begin
			rd_ptr_q <= rd_ptr_d;
			wr_ptr_q <= wr_ptr_d;
			cnt_q    <= cnt_d;
			uart_q   <= uart_d;
			irq_q    <= irq_d;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.exec) begin
			read_data_q  <= rd_d;
			irq_run_q    <= run_d;
			event_kind_q <= ek_d;
			event_byte_q <= eb_d;
		end
	end

	assign read_data  = read_data_q;
	assign irq_run    = irq_run_q;
	assign event_kind = event_kind_q;
	assign event_byte = event_byte_q;
	assign irq_line   = irq_q;
	assign uart_mode  = uart_q;
	assign fifo_count = cnt_q;

endmodule

`default_nettype wire

// ===== rtl/core/midi_uart_port_interface_unit.sv =====
// Top level of the MIDI UART port interface: controller plus datapath.
// Depends on muart_pkg, muart_ctrl and muart_dp.
//
//  channel  | handshake        | payload
//  ---------+------------------+---------------------------------------------
//  item in  | start, busy      | func, port_offset, data_byte
//  result   | done (one cycle) | read_data, irq_line, irq_run, event_kind,
//           |                  | event_byte, uart_mode, fifo_count
//
// For each item, the accept cycle reads the FIFO head from the
// registered memory port, the execute cycle updates state, and done shows the
// result in the following cycle. busy is high only in the execute cycle, so a
// new item can be accepted while the previous result is shown. The receiver
// cannot stall. Reset clears pointers, count and flags; FIFO contents are kept.
`default_nettype none

module midi_uart_port_interface_unit #(
	parameter int FIFO_DEPTH = 32
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              start,
	output logic                                   busy,
	input  wire logic [2:0]                        func,
	input  wire logic                              port_offset,
	input  wire logic [7:0]                        data_byte,
	output logic                                   done,
	output logic [7:0]                             read_data,
	output logic                                   irq_line,
	output logic                                   irq_run,
	output logic [2:0]                             event_kind,
	output logic [7:0]                             event_byte,
	output logic                                   uart_mode,
	output logic [$clog2(FIFO_DEPTH + 1)-1:0]      fifo_count
);

	localparam int PTR_W = $clog2(FIFO_DEPTH);
	localparam int CNT_W = $clog2(FIFO_DEPTH + 1);

	muart_pkg::cmd_t cmd;

	muart_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.done   (done),
		.cmd    (cmd)
	);

	muart_dp #(
		.FIFO_DEPTH (FIFO_DEPTH),
		.PTR_W      (PTR_W),
		.CNT_W      (CNT_W)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.func        (func),
		.port_offset (port_offset),
		.data_byte   (data_byte),
		.read_data   (read_data),
		.irq_line    (irq_line),
		.irq_run     (irq_run),
		.event_kind  (event_kind),
		.event_byte  (event_byte),
		.uart_mode   (uart_mode),
		.fifo_count  (fifo_count)
	);

	a_done_after_exec: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(busy))
		else $error("result strobe without an execute cycle");

	a_exec_one_cycle: assert property (@(posedge clk) disable iff (!arst_n)
		busy |=> !busy)
		else $error("execute state held longer than one cycle");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fifo_count <= CNT_W'(FIFO_DEPTH))
		else $error("FIFO count above depth");

	a_run_event: assert property (@(posedge clk) disable iff (!arst_n)
		(done && irq_run) |-> (event_kind == muart_pkg::EV_NONE ||
		                       event_kind == muart_pkg::EV_READ_FWD))
		else $error("data read with a foreign event");

	a_empty_no_irq_on_read: assert property (@(posedge clk) disable iff (!arst_n)
		(done && irq_run && fifo_count == '0) |-> !irq_line)
		else $error("interrupt still raised after a read emptied the FIFO");

endmodule

`default_nettype wire
